@@ src/lakv_pkg.sv @@
// Shared constants and types for the LRU age-counter key/value cache.
package lakv_pkg;

  localparam int DATA_W          = 64;
  localparam int OP_W            = 2;
  localparam int SLOT_W          = 6;
  localparam int DEF_NUM_ENTRIES = 64;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic load;
    logic eval;
  } lakv_cmd_t;

endpackage

@@ src/lakv_ctrl.sv @@
// Sequencer for the cache: accept, evaluate and commit, then present the result.
module lakv_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output lakv_pkg::lakv_cmd_t cmd
);
  import lakv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EVAL;
      S_EVAL: state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign cmd.load  = in_valid && (state_r == S_IDLE);
  assign cmd.eval  = (state_r == S_EVAL);

  a_load_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_EVAL) else $error("accepted beat did not start evaluation");
  a_eval_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval |=> out_valid) else $error("evaluation did not produce a result");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !cmd.load && !cmd.eval) else $error("new work while result pending");

endmodule

@@ src/lakv_dp.sv @@
// Datapath: key cells with parallel match, age counters, value memory, result registers.
module lakv_dp #(
  parameter int NUM_ENTRIES = lakv_pkg::DEF_NUM_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lakv_pkg::lakv_cmd_t        cmd,
  input  logic [lakv_pkg::OP_W-1:0]   in_opcode,
  input  logic [lakv_pkg::DATA_W-1:0] in_key_prime,
  input  logic [lakv_pkg::DATA_W-1:0] in_key_modulus,
  input  logic [lakv_pkg::DATA_W-1:0] in_key_exponent,
  input  logic [lakv_pkg::DATA_W-1:0] in_value_other_prime,
  input  logic [lakv_pkg::DATA_W-1:0] in_value_private_exp,
  output logic                       out_hit,
  output logic [lakv_pkg::DATA_W-1:0] out_found_other_prime,
  output logic [lakv_pkg::DATA_W-1:0] out_found_private_exp,
  output logic [lakv_pkg::SLOT_W-1:0] out_slot_used
);
  import lakv_pkg::*;

  localparam int IDX_W = $clog2(NUM_ENTRIES);
  localparam int AGE_W = $clog2(NUM_ENTRIES + 1);

  logic [OP_W-1:0]   op_r;
  logic [DATA_W-1:0] key_p_r, key_n_r, key_e_r, val_o_r, val_d_r;
  logic [NUM_ENTRIES-1:0] match_r, valid_r, valid_nxt;
  logic [AGE_W-1:0]  age_r [NUM_ENTRIES];
  logic [AGE_W-1:0]  age_nxt [NUM_ENTRIES];
  logic [DATA_W-1:0] kp_r [NUM_ENTRIES];
  logic [DATA_W-1:0] kn_r [NUM_ENTRIES];
  logic [DATA_W-1:0] ke_r [NUM_ENTRIES];
  logic [DATA_W-1:0] mem_o_r [NUM_ENTRIES];
  logic [DATA_W-1:0] mem_d_r [NUM_ENTRIES];
  logic [DATA_W-1:0] rd_o_r, rd_d_r;
  logic              hit_r;
  logic [SLOT_W-1:0] slot_r;

  logic [NUM_ENTRIES-1:0] hit_oh, free_vec, full_vec, cand, vic_oh, sel_oh;
  logic [IDX_W-1:0]  sel_idx;
  logic [AGE_W-1:0]  old_age, base;
  logic              hit_any, is_lookup, is_insert, is_clear;
  logic [SLOT_W+IDX_W-1:0] slot_wide;
  logic [NUM_ENTRIES-1:0] bad_age;

  // Capture the beat and match every valid entry against its key at once.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      key_p_r <= in_key_prime;
      key_n_r <= in_key_modulus;
      key_e_r <= in_key_exponent;
      val_o_r <= in_value_other_prime;
      val_d_r <= in_value_private_exp;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        match_r[i] <= valid_r[i] && kp_r[i] == in_key_prime &&
                      kn_r[i] == in_key_modulus && ke_r[i] == in_key_exponent;
      end
    end
  end

  assign is_lookup = (op_r == OP_LOOKUP);
  assign is_insert = (op_r == OP_INSERT);
  assign is_clear  = (op_r == OP_CLEAR);

  assign hit_any  = |match_r;
  assign hit_oh   = match_r & (~match_r + 1'b1);
  assign free_vec = ~valid_r;

  // Ages form a permutation of 1..count, so a full cache has exactly one oldest entry.
  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      full_vec[i] = (age_r[i] == AGE_W'(NUM_ENTRIES));
    end
  end

  assign cand   = (|free_vec) ? free_vec : full_vec;
  assign vic_oh = cand & (~cand + 1'b1);
  assign sel_oh = is_lookup ? hit_oh : vic_oh;

  always_comb begin
    sel_idx = '0;
    old_age = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (sel_oh[i]) begin
        sel_idx = sel_idx | IDX_W'(i);
        old_age = old_age | age_r[i];
      end
    end
  end

  assign slot_wide = {{SLOT_W{1'b0}}, sel_idx};

  always_comb begin
    valid_nxt = valid_r;
    base = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      age_nxt[i] = age_r[i];
    end
    if (is_clear) begin
      valid_nxt = '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        age_nxt[i] = '0;
      end
    end else if (is_insert) begin
      valid_nxt = valid_r | sel_oh;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        base = sel_oh[i] ? '0 : age_r[i];
        age_nxt[i] = valid_nxt[i] ? base + 1'b1 : base;
      end
    end else if (is_lookup && hit_any) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        base = sel_oh[i] ? '0 : age_r[i];
        age_nxt[i] = (valid_r[i] && base <= old_age) ? base + 1'b1 : base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else if (cmd.eval) begin
      valid_r <= valid_nxt;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        age_r[i] <= age_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && is_insert) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (sel_oh[i]) begin
          kp_r[i] <= key_p_r;
          kn_r[i] <= key_n_r;
          ke_r[i] <= key_e_r;
        end
      end
    end
  end

  // Value memory: one write port for inserts, one registered read for lookups.
  always_ff @(posedge clk) begin
    if (cmd.eval && is_insert) begin
      mem_o_r[sel_idx] <= val_o_r;
      mem_d_r[sel_idx] <= val_d_r;
    end
    if (cmd.eval && is_lookup) begin
      rd_o_r <= mem_o_r[sel_idx];
      rd_d_r <= mem_d_r[sel_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      hit_r  <= is_lookup && hit_any;
      slot_r <= ((is_lookup && hit_any) || is_insert) ? slot_wide[SLOT_W-1:0] : '0;
    end
  end

  assign out_hit               = hit_r;
  assign out_found_other_prime = hit_r ? rd_o_r : '0;
  assign out_found_private_exp = hit_r ? rd_d_r : '0;
  assign out_slot_used         = slot_r;

  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      bad_age[i] = valid_r[i] ? (age_r[i] == '0) : (age_r[i] != '0);
    end
  end

  a_age_valid: assert property (@(posedge clk) disable iff (!rst_n)
    bad_age == '0) else $error("age counter disagrees with valid bit");
  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval && is_insert |-> $onehot(sel_oh)) else $error("insert without a single victim");
  a_hit_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval && !is_lookup |=> !hit_r) else $error("hit reported for a non-lookup beat");

endmodule

@@ src/lru_age_key_value_cache.sv @@
// Top level of the fully associative key/value cache with age-counter LRU.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   opcode, three key tags, two value handles
//   out_     output     out_valid / out_stall hit, two found handles, slot used
//
// Each beat passes through S_IDLE, which captures it with a parallel key match, S_EVAL,
// which picks the entry and commits ages and stores, and S_OUT, which holds the result.
// A stalled result holds the block; the next input beat is taken once it leaves.
// Synchronous active-low reset empties the cache; no clearing pass is needed.
module lru_age_key_value_cache #(
  parameter int NUM_ENTRIES = lakv_pkg::DEF_NUM_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [lakv_pkg::OP_W-1:0]   in_opcode,
  input  logic [lakv_pkg::DATA_W-1:0] in_key_prime,
  input  logic [lakv_pkg::DATA_W-1:0] in_key_modulus,
  input  logic [lakv_pkg::DATA_W-1:0] in_key_exponent,
  input  logic [lakv_pkg::DATA_W-1:0] in_value_other_prime,
  input  logic [lakv_pkg::DATA_W-1:0] in_value_private_exp,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_hit,
  output logic [lakv_pkg::DATA_W-1:0] out_found_other_prime,
  output logic [lakv_pkg::DATA_W-1:0] out_found_private_exp,
  output logic [lakv_pkg::SLOT_W-1:0] out_slot_used
);
  import lakv_pkg::*;

  lakv_cmd_t cmd;

  lakv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lakv_dp #(.NUM_ENTRIES(NUM_ENTRIES)) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .in_opcode             (in_opcode),
    .in_key_prime          (in_key_prime),
    .in_key_modulus        (in_key_modulus),
    .in_key_exponent       (in_key_exponent),
    .in_value_other_prime  (in_value_other_prime),
    .in_value_private_exp  (in_value_private_exp),
    .out_hit               (out_hit),
    .out_found_other_prime (out_found_other_prime),
    .out_found_private_exp (out_found_private_exp),
    .out_slot_used         (out_slot_used)
  );

endmodule

@@ sim/lru_age_key_value_cache_tb.sv @@
// Testbench for the LRU age-counter key/value cache: directed and random beats checked by a predictor.
module lru_age_key_value_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lakv_pkg::*;

  localparam int N = DEF_NUM_ENTRIES;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic            hit;
    logic [63:0]     oq;
    logic [63:0]     od;
    logic [SLOT_W-1:0] slot;
  } answer_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid, out_hit;
  logic [OP_W-1:0] in_opcode = '0;
  logic [63:0] in_key_prime = '0, in_key_modulus = '0, in_key_exponent = '0;
  logic [63:0] in_value_other_prime = '0, in_value_private_exp = '0;
  logic [63:0] out_found_other_prime, out_found_private_exp;
  logic [SLOT_W-1:0] out_slot_used;

  lru_age_key_value_cache uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor copy of the cache.
  bit          c_valid [N];
  int unsigned c_age [N];
  logic [63:0] c_p [N], c_n [N], c_e [N], c_q [N], c_d [N];
  answer_t expected_answers[$];
  int errors = 0, beats_done = 0, hits_seen = 0, evictions = 0;
  int hold_off = 0;

  // Remembered keys for random lookups that are likely to hit.
  logic [63:0] known_p[$], known_n[$], known_e[$];

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch beat %0d: %s got %h want %h", beats_done, what, got, want);
  endtask

  function automatic answer_t predict_cache(logic [OP_W-1:0] op, logic [63:0] p, n, e, q, d);
    answer_t a;
    int v, oldest;
    int unsigned old_age;
    a = '{0, 0, 0, 0};
    if (op == OP_LOOKUP) begin
      for (int i = 0; i < N; i++) begin
        if (c_valid[i] && c_p[i] == p && c_n[i] == n && c_e[i] == e) begin
          old_age = c_age[i];
          c_age[i] = 0;
          for (int j = 0; j < N; j++)
            if (c_valid[j] && c_age[j] <= old_age) c_age[j]++;
          a = '{1, c_q[i], c_d[i], i[SLOT_W-1:0]};
          break;
        end
      end
    end else if (op == OP_INSERT) begin
      v = -1;
      oldest = 0;
      for (int i = 0; i < N; i++) begin
        if (!c_valid[i]) begin
          v = i;
          break;
        end
      end
      if (v < 0) begin
        evictions++;
        v = 0;
        for (int i = 0; i < N; i++)
          if (c_age[i] > oldest) begin
            oldest = c_age[i];
            v = i;
          end
      end
      c_valid[v] = 1; c_age[v] = 0;
      c_p[v] = p; c_n[v] = n; c_e[v] = e; c_q[v] = q; c_d[v] = d;
      for (int j = 0; j < N; j++) if (c_valid[j]) c_age[j]++;
      a.slot = v[SLOT_W-1:0];
    end else if (op == OP_CLEAR) begin
      for (int i = 0; i < N; i++) begin
        c_valid[i] = 0;
        c_age[i] = 0;
      end
    end
    return a;
  endfunction

  // Valid stays high into the next beat when there is no gap.
  task automatic send_beat(logic [OP_W-1:0] op, logic [63:0] p, n, e, q, d,
                           bit use_gap = 1);
    int gap;
    gap = use_gap ? $urandom_range(0, 18) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_opcode <= op;
    in_key_prime <= p; in_key_modulus <= n; in_key_exponent <= e;
    in_value_other_prime <= q; in_value_private_exp <= d;
    do @(posedge clk); while (in_stall);
    expected_answers.push_back(predict_cache(op, p, n, e, q, d));
    if (op == OP_INSERT) begin
      known_p.push_back(p); known_n.push_back(n); known_e.push_back(e);
    end
  endtask

  function automatic logic [63:0] r64();
    return {$urandom, $urandom};
  endfunction

  // Receiver: a random wait before each result beat, plus a long hold-off when requested.
  initial begin
    int w;
    forever begin
      if (hold_off > 0) begin
        out_stall <= 1;
        @(posedge clk);
        hold_off--;
      end else begin
        w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if (w > 0) begin
          out_stall <= 1;
          repeat (w) @(posedge clk);
        end
        out_stall <= 0;
        do @(posedge clk); while (!(rst_n && out_valid));
      end
    end
  end

  // Result checker.
  initial begin
    answer_t w;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        beats_done++;
        if (expected_answers.size() == 0) begin
          errors++;
          $display("unexpected result beat %0d", beats_done);
        end else begin
          w = expected_answers.pop_front();
          if (out_hit !== w.hit) report("hit", 64'(out_hit), 64'(w.hit));
          if (out_found_other_prime !== w.oq) report("other_prime", out_found_other_prime, w.oq);
          if (out_found_private_exp !== w.od) report("private_exp", out_found_private_exp, w.od);
          if (out_slot_used !== w.slot) report("slot", 64'(out_slot_used), 64'(w.slot));
          if (w.hit) hits_seen++;
        end
      end
    end
  end

  task automatic test_directed();
    logic [63:0] ones;
    ones = '1;
    send_beat(OP_LOOKUP, 0, 0, 0, 0, 0);                 // miss on empty cache
    send_beat(OP_INSERT, 0, 0, 0, ones, ones);
    send_beat(OP_INSERT, ones, ones, ones, 0, ones);
    send_beat(OP_INSERT, ones, ones, ones, 64'h5a, 64'ha5); // duplicate key
    send_beat(OP_LOOKUP, ones, ones, ones, 0, 0);        // first in index order wins
    send_beat(OP_LOOKUP, 0, 0, 0, 0, 0);
    send_beat(OP_LOOKUP, 0, ones, 0, 0, 0);              // partial match misses
    send_beat(OP_SPARE, ones, ones, ones, ones, ones);   // unused opcode
    send_beat(OP_LOOKUP, 0, 0, 0, 0, 0);
    send_beat(OP_CLEAR, ones, 0, ones, 0, ones);
    send_beat(OP_LOOKUP, 0, 0, 0, 0, 0);                 // miss after clear
  endtask

  task automatic test_fill_and_evict();
    known_p.delete(); known_n.delete(); known_e.delete();
    for (int i = 0; i < N + 8; i++)
      send_beat(OP_INSERT, 64'(i), ~64'(i), 64'h10001, r64(), r64(), 0);
    for (int i = 0; i < 6; i++)
      send_beat(OP_LOOKUP, 64'(i + 8), ~64'(i + 8), 64'h10001, 0, 0, 0);
  endtask

  task automatic test_backpressure();
    hold_off = 80;
    for (int i = 0; i < 8; i++)
      send_beat(OP_LOOKUP, 64'(i + 20), ~64'(i + 20), 64'h10001, 0, 0, 0);
  endtask

  task automatic test_random(int count);
    int k, sel;
    logic [OP_W-1:0] op;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      op = sel < 50 ? OP_LOOKUP : sel < 92 ? OP_INSERT : sel < 96 ? OP_CLEAR : OP_SPARE;
      if (op == OP_CLEAR) begin
        known_p.delete(); known_n.delete(); known_e.delete();
      end
      if (op == OP_LOOKUP && known_p.size() > 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, known_p.size() - 1);
        send_beat(op, known_p[k], known_n[k], known_e[k], r64(), r64());
      end else if ($urandom_range(0, 2) == 0) begin
        // Narrow keys to force duplicates.
        send_beat(op, 64'($urandom_range(0, 3)), 64'd7, 64'd3, r64(), r64());
      end else begin
        send_beat(op, r64(), r64(), r64(), r64(), r64());
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    test_directed();
    test_fill_and_evict();
    test_backpressure();
    test_random(520);
    in_valid <= 0;
    while (expected_answers.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered: lookups, inserts, clears, unused opcode, %0d hits, %0d evictions,",
             hits_seen, evictions);
    $display("duplicate keys, a full cache and a long output stall; %0d results checked",
             beats_done);
    if (errors == 0) $display("lru_age_key_value_cache_tb OK");
    else $display("lru_age_key_value_cache_tb NOT OK");
    $finish;
  end

  initial begin
    #3ms;
    $display("lru_age_key_value_cache_tb NOT OK");
    $finish;
  end
endmodule
